FILE: design/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared field widths, mode codes and status codes of the safety allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int MODE_WIDTH    = 3;
   localparam int PROCESS_WIDTH = 3;
   localparam int COUNT_WIDTH   = 8;
   localparam int STATUS_WIDTH  = 3;
   localparam int SEQ_WIDTH     = 3;
   localparam int NUM_RES       = 3;
   localparam int MAX_RESULTS   = 8;

   localparam logic [MODE_WIDTH-1:0] MODE_LOAD_CLAIM = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_LOAD_ALLOC = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_LOAD_AVAIL = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_REQUEST    = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_CHECK      = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_LOADED      = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_GRANTED     = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVER_CLAIM  = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_MUST_WAIT   = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DENIED      = 3'd4;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SAFE        = 3'd5;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNSAFE      = 3'd6;
   localparam logic [STATUS_WIDTH-1:0] STATUS_LOAD_REJECT = 3'd7;

endpackage

FILE: design/bsa_if.sv
// ----------------------------------------------------------------------------
// bsa_if
// Valid/ready channels that carry request words and result words.
// ----------------------------------------------------------------------------
interface bsa_req_if import bsa_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_WIDTH-1:0]    mode;
   logic [PROCESS_WIDTH-1:0] process;
   logic [COUNT_WIDTH-1:0]   count_a;
   logic [COUNT_WIDTH-1:0]   count_b;
   logic [COUNT_WIDTH-1:0]   count_c;

   modport source (output valid, mode, process, count_a, count_b, count_c, input ready);
   modport sink (input valid, mode, process, count_a, count_b, count_c, output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] status;
   logic [SEQ_WIDTH-1:0]    seq_process;
   logic                    last;

   modport source (output valid, status, seq_process, last, input ready);
   modport sink (input valid, status, seq_process, last, output ready);
endinterface

FILE: design/bsa_row_mem.sv
// ----------------------------------------------------------------------------
// bsa_row_mem
// Claim and allocation rows in a synchronous memory with registered read.
// Rows never written since reset read as zero.
// ----------------------------------------------------------------------------
module bsa_row_mem #(
   parameter int NUM_ROWS = 8,
   parameter int ROW_BITS = 48
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       wr_en,
   input  logic [(NUM_ROWS > 1 ? $clog2(NUM_ROWS) : 1)-1:0] wr_addr,
   input  logic [ROW_BITS-1:0]                        wr_data,
   input  logic [(NUM_ROWS > 1 ? $clog2(NUM_ROWS) : 1)-1:0] rd_addr,
   output logic [ROW_BITS-1:0]                        rd_data
);

   logic [ROW_BITS-1:0] mem [NUM_ROWS];
   logic [NUM_ROWS-1:0] valid_ff;
   logic [ROW_BITS-1:0] data_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? data_ff : '0;

endmodule

FILE: design/bankers_safety_allocator_unit.sv
// ----------------------------------------------------------------------------
// bankers_safety_allocator_unit
// Loads and rejected requests end in a single result word; checks and requests
// that reach the scan walk the row memory one row per cycle, in passes over all
// processes, until every process has finished or a pass makes no progress.
// Sequence words then follow one a cycle while the result channel takes them.
// One word is in work at a time.
// Synchronous reset empties the tables and the available vector at once.
// ----------------------------------------------------------------------------
module bankers_safety_allocator_unit import bsa_pkg::*; #(
   parameter int NUM_PROCESSES = 8,
   parameter int COUNT_BITS    = 8
) (
   input logic    clock,
   input logic    reset,
   bsa_req_if.sink   req_chan,
   bsa_rsp_if.source rsp_chan
);

   localparam int PIDX_W   = NUM_PROCESSES > 1 ? $clog2(NUM_PROCESSES) : 1;
   localparam int CNT_W    = $clog2(NUM_PROCESSES + 1);
   localparam int WORK_W   = COUNT_BITS + $clog2(NUM_PROCESSES + 1);
   localparam int ROW_W    = 2 * NUM_RES * COUNT_BITS;
   localparam int NUM_EMIT = NUM_PROCESSES < MAX_RESULTS ? NUM_PROCESSES : MAX_RESULTS;
   localparam int K_W      = NUM_EMIT > 1 ? $clog2(NUM_EMIT) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROW,
      S_CHECK_INIT,
      S_SCAN,
      S_FINISH,
      S_EMIT_ONE,
      S_EMIT_SEQ
   } state_type;

   state_type               state_ff, state_in;
   logic [MODE_WIDTH-1:0]   mode_ff, mode_in;
   logic [PIDX_W-1:0]       proc_ff, proc_in;
   logic [COUNT_BITS-1:0]   v_ff [NUM_RES];
   logic [COUNT_BITS-1:0]   v_in [NUM_RES];
   logic [COUNT_BITS-1:0]   avail_ff [NUM_RES];
   logic [COUNT_BITS-1:0]   avail_in [NUM_RES];
   logic [COUNT_BITS-1:0]   avail_save_ff [NUM_RES];
   logic [COUNT_BITS-1:0]   avail_save_in [NUM_RES];
   logic [ROW_W-1:0]        row_save_ff, row_save_in;
   logic [WORK_W-1:0]       work_ff [NUM_RES];
   logic [WORK_W-1:0]       work_in [NUM_RES];
   logic [NUM_PROCESSES-1:0] fin_ff, fin_in;
   logic [SEQ_WIDTH-1:0]    seq_ff [NUM_PROCESSES];
   logic [SEQ_WIDTH-1:0]    seq_in [NUM_PROCESSES];
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PIDX_W-1:0]       idx_ff, idx_in;
   logic                    prog_ff, prog_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [STATUS_WIDTH-1:0] emit_status_ff, emit_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [SEQ_WIDTH-1:0]    rsp_seq_ff, rsp_seq_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    mem_wr_en;
   logic [ROW_W-1:0]        mem_wr_data;
   logic [PIDX_W-1:0]       mem_rd_addr;
   logic [ROW_W-1:0]        row_rd;

   logic [COUNT_BITS-1:0]   claim_rd [NUM_RES];
   logic [COUNT_BITS-1:0]   alloc_rd [NUM_RES];
   logic [COUNT_BITS-1:0]   need_rd [NUM_RES];
   logic [COUNT_BITS-1:0]   req_v [NUM_RES];
   logic                    lt_alloc, gt_claim, gt_need, gt_avail, need_fits, fits;
   logic [ROW_W-1:0]        row_claim, row_alloc, row_grant;
   logic                    accept, slot_free, out_of_range, end_pass;
   logic [CNT_W-1:0]        count_inc;
   logic                    prog_inc;

   bsa_row_mem #(
      .NUM_ROWS (NUM_PROCESSES),
      .ROW_BITS (ROW_W)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (proc_ff),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (row_rd)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign out_of_range   = int'(req_chan.process) >= NUM_PROCESSES;
   assign end_pass       = (idx_ff == PIDX_W'(NUM_PROCESSES - 1));

   assign req_v[0] = COUNT_BITS'(req_chan.count_a);
   assign req_v[1] = COUNT_BITS'(req_chan.count_b);
   assign req_v[2] = COUNT_BITS'(req_chan.count_c);

   always_comb begin
      lt_alloc  = 1'b0;
      gt_claim  = 1'b0;
      gt_need   = 1'b0;
      gt_avail  = 1'b0;
      need_fits = 1'b1;
      row_claim = row_rd;
      row_alloc = row_rd;
      row_grant = row_rd;
      for (int r = 0; r < NUM_RES; r++) begin
         claim_rd[r] = row_rd[r*COUNT_BITS +: COUNT_BITS];
         alloc_rd[r] = row_rd[(NUM_RES+r)*COUNT_BITS +: COUNT_BITS];
         need_rd[r]  = (alloc_rd[r] > claim_rd[r]) ? '0 : claim_rd[r] - alloc_rd[r];
         lt_alloc    = lt_alloc | (v_ff[r] < alloc_rd[r]);
         gt_claim    = gt_claim | (v_ff[r] > claim_rd[r]);
         gt_need     = gt_need | (v_ff[r] > need_rd[r]);
         gt_avail    = gt_avail | (v_ff[r] > avail_ff[r]);
         need_fits   = need_fits & (WORK_W'(need_rd[r]) <= work_ff[r]);
         row_claim[r*COUNT_BITS +: COUNT_BITS]           = v_ff[r];
         row_alloc[(NUM_RES+r)*COUNT_BITS +: COUNT_BITS] = v_ff[r];
         row_grant[(NUM_RES+r)*COUNT_BITS +: COUNT_BITS] = alloc_rd[r] + v_ff[r];
      end
      fits      = need_fits && !fin_ff[idx_ff];
      count_inc = count_ff + CNT_W'(fits);
      prog_inc  = prog_ff | fits;
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      proc_in        = proc_ff;
      v_in           = v_ff;
      avail_in       = avail_ff;
      avail_save_in  = avail_save_ff;
      row_save_in    = row_save_ff;
      work_in        = work_ff;
      fin_in         = fin_ff;
      seq_in         = seq_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      prog_in        = prog_ff;
      k_in           = k_ff;
      emit_status_in = emit_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_seq_in     = rsp_seq_ff;
      rsp_last_in    = rsp_last_ff;
      mem_wr_en      = 1'b0;
      mem_wr_data    = row_rd;
      mem_rd_addr    = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            mem_rd_addr = PIDX_W'(req_chan.process);
            if (accept) begin
               mode_in = req_chan.mode;
               proc_in = PIDX_W'(req_chan.process);
               v_in    = req_v;
               case (req_chan.mode) inside
                  MODE_LOAD_CLAIM, MODE_LOAD_ALLOC, MODE_REQUEST: begin
                     if (out_of_range) begin
                        emit_status_in = (req_chan.mode == MODE_REQUEST) ?
                                         STATUS_OVER_CLAIM : STATUS_LOAD_REJECT;
                        state_in       = S_EMIT_ONE;
                     end else begin
                        state_in = S_ROW;
                     end
                  end
                  MODE_LOAD_AVAIL: begin
                     avail_in       = req_v;
                     emit_status_in = STATUS_LOADED;
                     state_in       = S_EMIT_ONE;
                  end
                  MODE_CHECK: begin
                     state_in = S_CHECK_INIT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ROW: begin
            state_in = S_EMIT_ONE;
            case (mode_ff)
               MODE_LOAD_CLAIM: begin
                  if (lt_alloc) begin
                     emit_status_in = STATUS_LOAD_REJECT;
                  end else begin
                     mem_wr_en      = 1'b1;
                     mem_wr_data    = row_claim;
                     emit_status_in = STATUS_LOADED;
                  end
               end
               MODE_LOAD_ALLOC: begin
                  if (gt_claim) begin
                     emit_status_in = STATUS_LOAD_REJECT;
                  end else begin
                     mem_wr_en      = 1'b1;
                     mem_wr_data    = row_alloc;
                     emit_status_in = STATUS_LOADED;
                  end
               end
               default: begin
                  if (gt_need) begin
                     emit_status_in = STATUS_OVER_CLAIM;
                  end else if (gt_avail) begin
                     emit_status_in = STATUS_MUST_WAIT;
                  end else begin
                     mem_wr_en     = 1'b1;
                     mem_wr_data   = row_grant;
                     row_save_in   = row_rd;
                     avail_save_in = avail_ff;
                     for (int r = 0; r < NUM_RES; r++) begin
                        avail_in[r] = avail_ff[r] - v_ff[r];
                     end
                     state_in = S_CHECK_INIT;
                  end
               end
            endcase
         end
         S_CHECK_INIT: begin
            for (int r = 0; r < NUM_RES; r++) begin
               work_in[r] = WORK_W'(avail_ff[r]);
            end
            fin_in      = '0;
            count_in    = '0;
            idx_in      = '0;
            prog_in     = 1'b0;
            mem_rd_addr = '0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            if (fits) begin
               for (int r = 0; r < NUM_RES; r++) begin
                  work_in[r] = work_ff[r] + WORK_W'(alloc_rd[r]);
               end
               fin_in[idx_ff] = 1'b1;
               seq_in[count_ff[PIDX_W-1:0]] = SEQ_WIDTH'(idx_ff);
            end
            count_in = count_inc;
            prog_in  = prog_inc;
            if (end_pass) begin
               idx_in      = '0;
               prog_in     = 1'b0;
               mem_rd_addr = '0;
               if ((count_inc == CNT_W'(NUM_PROCESSES)) || !prog_inc) begin
                  state_in = S_FINISH;
               end
            end else begin
               idx_in      = idx_ff + 1'b1;
               mem_rd_addr = idx_ff + 1'b1;
            end
         end
         S_FINISH: begin
            k_in = '0;
            if (count_ff == CNT_W'(NUM_PROCESSES)) begin
               emit_status_in = (mode_ff == MODE_REQUEST) ? STATUS_GRANTED : STATUS_SAFE;
               state_in       = S_EMIT_SEQ;
            end else if (mode_ff == MODE_REQUEST) begin
               mem_wr_en      = 1'b1;
               mem_wr_data    = row_save_ff;
               avail_in       = avail_save_ff;
               emit_status_in = STATUS_DENIED;
               state_in       = S_EMIT_ONE;
            end else begin
               emit_status_in = STATUS_UNSAFE;
               state_in       = S_EMIT_ONE;
            end
         end
         S_EMIT_ONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = emit_status_ff;
               rsp_seq_in    = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_EMIT_SEQ: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = emit_status_ff;
               rsp_seq_in    = seq_ff[PIDX_W'(k_ff)];
               rsp_last_in   = (k_ff == K_W'(NUM_EMIT - 1));
               k_in          = k_ff + 1'b1;
               if (k_ff == K_W'(NUM_EMIT - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      proc_ff        <= proc_in;
      v_ff           <= v_in;
      avail_save_ff  <= avail_save_in;
      row_save_ff    <= row_save_in;
      work_ff        <= work_in;
      seq_ff         <= seq_in;
      count_ff       <= count_in;
      idx_ff         <= idx_in;
      prog_ff        <= prog_in;
      k_ff           <= k_in;
      emit_status_ff <= emit_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_seq_ff     <= rsp_seq_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= '0;
         for (int r = 0; r < NUM_RES; r++) begin
            avail_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fin_ff       <= fin_in;
         avail_ff     <= avail_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.seq_process = rsp_seq_ff;
   assign rsp_chan.last        = rsp_last_ff;

endmodule
